// ===== hw/rtl/pt64_pkg.sv =====
package pt64_pkg;

	localparam int NumBases = 7;
	localparam int BaseW = 31;

	localparam logic [BaseW-1:0] BASES [NumBases] = '{
		31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504, 31'd1795265022
	};

	localparam logic [1:0] SEL_RED = 2'd0;
	localparam logic [1:0] SEL_SQ  = 2'd1;
	localparam logic [1:0] SEL_MUL = 2'd2;

	typedef struct packed {
		logic       load;
		logic       strip;
		logic       mul_go;
		logic [1:0] mul_sel;
		logic       wr_a;
		logic       wr_r;
		logic       r_one;
		logic       bit_dec;
		logic       k_inc;
		logic       sq_init;
		logic       sq_dec;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic le1;
		logic even;
		logic is2;
		logic is3;
		logic d_even;
		logic mul_done;
		logic a_zero;
		logic r_one;
		logic r_nm1;
		logic dbit;
		logic bit_last;
		logic k_last;
		logic sq_more;
	} stat_t;

endpackage

// ===== hw/rtl/pt64_mulmod.sv =====
module pt64_mulmod import pt64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] x,
	input  logic [63:0] y,
	input  logic [63:0] m,
	output logic        done,
	output logic [63:0] res
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] m_q;
	logic [63:0] t0;
	logic [63:0] t1;
	logic [63:0] t2;

	always_comb begin
		t0 = {acc_q[62:0], 1'b0};
		if (t0 >= m_q) t0 = t0 - m_q;
		t1 = t0 + x_q;
		if (t1 >= m_q) t1 = t1 - m_q;
		t2 = y_q[63] ? t1 : t0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= t2;
			y_q   <= {y_q[62:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = acc_q;

endmodule

// ===== hw/rtl/pt64_dp.sv =====
module pt64_dp import pt64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [63:0] candidate,
	output stat_t       st
);

	logic [63:0] n_q;
	logic [63:0] d_q;
	logic [5:0]  s_q;
	logic [2:0]  k_q;
	logic [5:0]  bit_q;
	logic [5:0]  sq_q;
	logic [63:0] a_q;
	logic [63:0] r_q;
	logic [63:0] nm1;
	logic [63:0] mx;
	logic [63:0] my;
	logic        mdone;
	logic [63:0] mres;

	assign nm1 = n_q - 64'd1;

	always_comb begin
		mx = r_q;
		my = r_q;
		case (cmd.mul_sel)
			SEL_RED: begin
				mx = 64'd1;
				my = {{(64-BaseW){1'b0}}, BASES[k_q]};
			end
			SEL_SQ:  my = r_q;
			SEL_MUL: my = a_q;
			default: my = r_q;
		endcase
	end

	pt64_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.x      (mx),
		.y      (my),
		.m      (n_q),
		.done   (mdone),
		.res    (mres)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= candidate;
			d_q <= candidate - 64'd1;
			s_q <= '0;
			k_q <= '0;
		end
		if (cmd.strip) begin
			d_q <= {1'b0, d_q[63:1]};
			s_q <= s_q + 6'd1;
		end
		if (cmd.k_inc) k_q <= k_q + 3'd1;
		if (cmd.wr_a) a_q <= mres;
		if (cmd.wr_r) r_q <= mres;
		if (cmd.r_one) begin
			r_q   <= 64'd1;
			bit_q <= 6'd63;
		end
		if (cmd.bit_dec) bit_q <= bit_q - 6'd1;
		if (cmd.sq_init) sq_q <= s_q;
		if (cmd.sq_dec) sq_q <= sq_q - 6'd1;
	end

	always_comb begin
		st.neg      = n_q[63];
		st.le1      = n_q <= 64'd1;
		st.even     = !n_q[0];
		st.is2      = n_q == 64'd2;
		st.is3      = n_q == 64'd3;
		st.d_even   = !d_q[0];
		st.mul_done = mdone;
		st.a_zero   = a_q == 64'd0;
		st.r_one    = r_q == 64'd1;
		st.r_nm1    = r_q == nm1;
		st.dbit     = d_q[bit_q];
		st.bit_last = bit_q == 6'd0;
		st.k_last   = k_q == 3'(NumBases - 1);
		st.sq_more  = sq_q > 6'd1;
	end

endmodule

// ===== hw/rtl/pt64_ctrl.sv =====
module pt64_ctrl import pt64_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	output logic  is_prime,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_CLASS   = 4'd1;
	localparam logic [3:0] ST_STRIP   = 4'd2;
	localparam logic [3:0] ST_RED_GO  = 4'd3;
	localparam logic [3:0] ST_RED_W   = 4'd4;
	localparam logic [3:0] ST_RED_CHK = 4'd5;
	localparam logic [3:0] ST_PSQ_GO  = 4'd6;
	localparam logic [3:0] ST_PSQ_W   = 4'd7;
	localparam logic [3:0] ST_PBIT    = 4'd8;
	localparam logic [3:0] ST_PMUL_W  = 4'd9;
	localparam logic [3:0] ST_PEND    = 4'd10;
	localparam logic [3:0] ST_CHK1    = 4'd11;
	localparam logic [3:0] ST_SQ_CHK  = 4'd12;
	localparam logic [3:0] ST_SQ_W    = 4'd13;
	localparam logic [3:0] ST_NEXT    = 4'd14;
	localparam logic [3:0] ST_DONE    = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       res_q;
	logic       res_d;
	logic       out_valid_q;
	logic       is_prime_q;
	logic       accept;

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			ST_IDLE: if (accept) begin
				cmd.load = 1'b1;
				state_d  = ST_CLASS;
			end
			ST_CLASS: begin
				if (st.neg || st.le1) begin
					res_d = 1'b0; state_d = ST_DONE;
				end else if (st.even) begin
					res_d = st.is2; state_d = ST_DONE;
				end else if (st.is3) begin
					res_d = 1'b1; state_d = ST_DONE;
				end else state_d = ST_STRIP;
			end
			ST_STRIP: begin
				if (st.d_even) cmd.strip = 1'b1;
				else state_d = ST_RED_GO;
			end
			ST_RED_GO: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = SEL_RED; state_d = ST_RED_W;
			end
			ST_RED_W: if (st.mul_done) begin
				cmd.wr_a = 1'b1; state_d = ST_RED_CHK;
			end
			ST_RED_CHK: begin
				if (st.a_zero) state_d = ST_NEXT;
				else begin
					cmd.r_one = 1'b1; state_d = ST_PSQ_GO;
				end
			end
			ST_PSQ_GO: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = SEL_SQ; state_d = ST_PSQ_W;
			end
			ST_PSQ_W: if (st.mul_done) begin
				cmd.wr_r = 1'b1; state_d = ST_PBIT;
			end
			ST_PBIT: begin
				if (st.dbit) begin
					cmd.mul_go = 1'b1; cmd.mul_sel = SEL_MUL; state_d = ST_PMUL_W;
				end else state_d = ST_PEND;
			end
			ST_PMUL_W: if (st.mul_done) begin
				cmd.wr_r = 1'b1; state_d = ST_PEND;
			end
			ST_PEND: begin
				if (st.bit_last) state_d = ST_CHK1;
				else begin
					cmd.bit_dec = 1'b1; state_d = ST_PSQ_GO;
				end
			end
			ST_CHK1: begin
				if (st.r_one || st.r_nm1) state_d = ST_NEXT;
				else begin
					cmd.sq_init = 1'b1; state_d = ST_SQ_CHK;
				end
			end
			ST_SQ_CHK: begin
				if (st.r_nm1) state_d = ST_NEXT;
				else if (st.sq_more) begin
					cmd.mul_go = 1'b1; cmd.mul_sel = SEL_SQ; cmd.sq_dec = 1'b1;
					state_d = ST_SQ_W;
				end else begin
					res_d = 1'b0; state_d = ST_DONE;
				end
			end
			ST_SQ_W: if (st.mul_done) begin
				cmd.wr_r = 1'b1; state_d = ST_SQ_CHK;
			end
			ST_NEXT: begin
				if (st.k_last) begin
					res_d = 1'b1; state_d = ST_DONE;
				end else begin
					cmd.k_inc = 1'b1; state_d = ST_RED_GO;
				end
			end
			ST_DONE: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) is_prime_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	a_accept_class: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CLASS)
		else $error("request accepted but controller did not start");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.mul_done |-> (state_q == ST_RED_W || state_q == ST_PSQ_W ||
			state_q == ST_PMUL_W || state_q == ST_SQ_W))
		else $error("multiplier finished outside a wait state");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=> out_valid_q)
		else $error("result not presented");

endmodule

// ===== hw/rtl/primality_test_64bit_unit.sv =====
// Deterministic Miller-Rabin test with bases 2, 325, 9375, 28178, 450775,
// 9780504, 1795265022: is_prime is exact for every signed 64-bit candidate.
// One request at a time. Negative, zero, one, even values and three are settled
// in the classify state. Other values run on one shift-and-add modular multiplier;
// each base costs one reduction, 64 squarings, one multiply per set bit of d, and
// up to s-1 further squarings (n-1 = d*2^s).
// A finished result waits in an output register while the next request is taken.
module primality_test_64bit_unit import pt64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [63:0] candidate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_prime
);

	cmd_t  cmd;
	stat_t st;

	pt64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_prime  (is_prime),
		.st        (st),
		.cmd       (cmd)
	);

	pt64_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.candidate (candidate),
		.st        (st)
	);

endmodule

// ===== tb/tb_primality_test_64bit.sv =====
module tb_primality_test_64bit_unit;
	import pt64_pkg::*;

	localparam int IdlePct = 13;
	localparam int StallLimit = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [63:0] candidate;
	logic out_valid;
	logic out_stall;
	logic is_prime;

	logic [63:0] pending_candidates[$];
	logic [63:0] verdict_candidates[$];
	logic        expected_verdicts[$];
	int          n_sent;
	int          n_checked;
	int          n_errors;
	int          idle_cycles;

	primality_test_64bit_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.candidate(candidate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_prime(is_prime)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		p = p % {64'd0, m};
		return p[63:0];
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] x, logic [63:0] e, logic [63:0] m);
		logic [63:0] r;
		r = 64'd1 % m;
		while (e != 64'd0) begin
			if (e[0])
				r = mulmod(r, x, m);
			e = e >> 1;
			if (e != 64'd0)
				x = mulmod(x, x, m);
		end
		return r;
	endfunction

	function automatic logic primality_of(logic [63:0] v);
		logic [63:0] nm1;
		logic [63:0] d;
		logic [63:0] a;
		int s;
		logic found;
		if (v[63])
			return 1'b0;
		if (v <= 64'd1)
			return 1'b0;
		if (!v[0])
			return v == 64'd2;
		if (v == 64'd3)
			return 1'b1;
		nm1 = v - 64'd1;
		d = nm1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		for (int k = 0; k < NumBases; k++) begin
			a = {33'd0, BASES[k]} % v;
			if (a == 64'd0)
				continue;
			a = powmod(a, d, v);
			if (a == 64'd1 || a == nm1)
				continue;
			found = 1'b0;
			for (int i = 0; i < s - 1; i++) begin
				a = mulmod(a, a, v);
				if (a == nm1) begin
					found = 1'b1;
					break;
				end
			end
			if (!found)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH: %s", what);
		n_errors++;
	endtask

	task automatic add_candidate(logic [63:0] v);
		pending_candidates.insert(pending_candidates.size(), v);
	endtask

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			candidate <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				verdict_candidates.insert(verdict_candidates.size(), candidate);
				expected_verdicts.insert(expected_verdicts.size(), primality_of(candidate));
			end
			if (!in_valid || !in_stall) begin
				if (pending_candidates.size() > 0 &&
				    ((n_sent >= 40 && n_sent < 80) || $urandom_range(99) >= IdlePct)) begin
					in_valid <= 1'b1;
					candidate <= pending_candidates.pop_front();
					n_sent <= n_sent + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("unexpected result is_prime=%0b", is_prime));
				end else begin
					if (is_prime !== expected_verdicts[0])
						report_mismatch($sformatf("candidate %0d: is_prime=%0b expected %0b",
							$signed(verdict_candidates[0]), is_prime, expected_verdicts[0]));
					void'(expected_verdicts.pop_front());
					void'(verdict_candidates.pop_front());
				end
				n_checked <= n_checked + 1;
			end
			if (n_checked >= 40 && n_checked < 80)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < IdlePct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [63:0] v;
		logic [63:0] mask;
		int w;
		int r;
		n_sent = 0;
		n_checked = 0;
		n_errors = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		candidate = '0;
		out_stall = 1'b0;

		// directed: signs, trivial values, small primes with skipped bases,
		// strong pseudoprimes, extremes
		add_candidate(64'h8000_0000_0000_0000);
		add_candidate(64'hFFFF_FFFF_FFFF_FFFF);
		add_candidate(64'hFFFF_FFFF_FFFF_FFFD);
		add_candidate(64'd0);
		add_candidate(64'd1);
		add_candidate(64'd2);
		add_candidate(64'd3);
		add_candidate(64'd4);
		add_candidate(64'd5);
		add_candidate(64'd9);
		add_candidate(64'd13);
		add_candidate(64'd2047);
		add_candidate(64'd3215031751);
		add_candidate(64'd2147483647);
		add_candidate(64'd1795265022);
		add_candidate(64'd1795265023);
		add_candidate(64'd4294967291);
		add_candidate(64'd2305843009213693951);
		add_candidate(64'd9223372036854775783);
		add_candidate(64'h7FFF_FFFF_FFFF_FFFF);
		add_candidate(64'h7FFF_FFFF_FFFF_FFFE);
		add_candidate(64'd3825123056546413051);

		for (int i = 0; i < 128; i++) begin
			v = {$urandom, $urandom};
			r = $urandom_range(99);
			if (r < 10) begin
			end else if (r < 20) begin
				v[63] = 1'b1;
			end else if (r < 30) begin
				v[0] = 1'b0;
			end else begin
				w = (r < 88) ? $urandom_range(2, 24) : $urandom_range(25, 63);
				mask = (64'd1 << w) - 64'd1;
				v = (v & mask) | (64'd1 << (w - 1)) | 64'd1;
			end
			add_candidate(v);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_candidates.size() == 0 && !in_valid && expected_verdicts.size() == 0);
		repeat (100) @(posedge clk);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== primality_test_64bit_unit.f =====
hw/rtl/pt64_pkg.sv
hw/rtl/pt64_mulmod.sv
hw/rtl/pt64_dp.sv
hw/rtl/pt64_ctrl.sv
hw/rtl/primality_test_64bit_unit.sv
tb/tb_primality_test_64bit.sv
